// File: hw/rtl/arp_icmp_echo_responder_unit_assert.svh
// Assertion macros used by the checker file of the responder.
`ifndef ARP_ICMP_ECHO_RESPONDER_UNIT_ASSERT_SVH
`define ARP_ICMP_ECHO_RESPONDER_UNIT_ASSERT_SVH

// Clocked assertion with no reset qualifier.
`define AIER_ASSERT_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Clocked assertion on clk_i, switched off while rst_ni is low.
`define AIER_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

// File: hw/rtl/aier_pkg.sv
// ----------------------------------------------------------------------------
// aier_pkg
// Types and constants of the ARP and ICMP echo responder.
// ----------------------------------------------------------------------------
package aier_pkg;

  localparam int unsigned HdrLen   = 42;
  localparam int unsigned PosW     = $clog2(HdrLen);
  localparam int unsigned MacW     = 48;
  localparam int unsigned IpW      = 32;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = MacW;
  localparam int unsigned SumW     = 20;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOurMac = 1'b0,
    CfgOurIp  = 1'b1
  } cfg_idx_e;

  localparam logic [MacW-1:0] OurMacReset = '0;
  localparam logic [IpW-1:0]  OurIpReset  = 32'hc0a8_0266;

  localparam logic [15:0] EtherTypeArp  = 16'h0806;
  localparam logic [15:0] ArpOpRequest  = 16'h0001;
  localparam logic [15:0] ArpOpReply    = 16'h0002;
  localparam logic [7:0]  IpProtoIcmp   = 8'h01;
  localparam logic [7:0]  IcmpEchoReply = 8'h00;

  localparam logic [PosW-1:0] PosLast     = PosW'(HdrLen - 1);
  localparam logic [PosW-1:0] PosHdrEnd   = PosW'(HdrLen);
  localparam logic [PosW-1:0] PosEtype    = PosW'(12);
  localparam logic [PosW-1:0] PosArpOp    = PosW'(20);
  localparam logic [PosW-1:0] PosIpProto  = PosW'(23);
  localparam logic [PosW-1:0] PosIcmpType = PosW'(34);
  localparam logic [PosW-1:0] PosIcmpCk   = PosW'(36);
  localparam logic [PosW-1:0] PosArpTip   = PosW'(38);

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       reply_end;
    logic       reply_kind;
  } out_t;

  typedef struct packed {
    logic capture;
    logic calc;
    logic issue;
    logic load_hdr;
    logic load_pass;
  } cmd_t;

  typedef struct packed {
    logic pos_last;
    logic end_hdr;
    logic is_arp;
    logic is_icmp;
    logic issue_done;
    logic pend;
    logic out_free;
  } sts_t;

endpackage

// File: hw/rtl/aier_ram.sv
// ----------------------------------------------------------------------------
// aier_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aier_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 42
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/aier_ctrl.sv
// ----------------------------------------------------------------------------
// aier_ctrl
// Frame sequencer: header collection, rewrite, header release and payload pass or discard.
// ----------------------------------------------------------------------------
module aier_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_end_i,
  output logic          in_ready_o,
  input  aier_pkg::sts_t sts_i,
  output aier_pkg::cmd_t cmd_o
);
  import aier_pkg::*;

  typedef enum logic [2:0] {
    StCollect,
    StCalc,
    StRelease,
    StPass,
    StDiscard
  } state_e;

  state_e state_q, state_d;
  logic   acc;

  always_comb begin
    case (state_q)
      StCollect: in_ready_o = 1'b1;
      StPass:    in_ready_o = sts_i.out_free;
      StDiscard: in_ready_o = 1'b1;
      default:   in_ready_o = 1'b0;
    endcase
  end

  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.capture   = acc && (state_q == StCollect);
    cmd_o.calc      = (state_q == StCalc);
    cmd_o.issue     = (state_q == StRelease) && !sts_i.issue_done &&
                      (!sts_i.pend || sts_i.out_free);
    cmd_o.load_hdr  = (state_q == StRelease) && sts_i.pend && sts_i.out_free;
    cmd_o.load_pass = acc && (state_q == StPass);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StCollect: begin
        if (acc && sts_i.pos_last) begin
          state_d = StCalc;
        end
      end
      StCalc: begin
        if (sts_i.is_arp || sts_i.is_icmp) begin
          state_d = StRelease;
        end else if (sts_i.end_hdr) begin
          state_d = StCollect;
        end else begin
          state_d = StDiscard;
        end
      end
      StRelease: begin
        if (sts_i.issue_done && !sts_i.pend) begin
          state_d = sts_i.end_hdr ? StCollect : StPass;
        end
      end
      StPass, StDiscard: begin
        if (acc && in_end_i) begin
          state_d = StCollect;
        end
      end
      default: state_d = StCollect;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StCollect;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/aier_dp.sv
// ----------------------------------------------------------------------------
// aier_dp
// Datapath: header store, field capture, checksums, byte rewrite and output.
// ----------------------------------------------------------------------------
module aier_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  aier_pkg::cmd_t                 cmd_i,
  output aier_pkg::sts_t                 sts_o,
  input  aier_pkg::in_t                  in_data_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output aier_pkg::out_t                 out_data_o,
  input  logic                           cfg_we_i,
  input  logic [aier_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [aier_pkg::CfgDataW-1:0]  cfg_data_i
);
  import aier_pkg::*;

  logic [MacW-1:0] mac_q;
  logic [IpW-1:0]  ip_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] iss_q, iss_d;
  logic [PosW-1:0] pidx_q;
  logic            pend_q, pend_d;
  logic            out_valid_q, out_valid_d;
  out_t            out_q;

  logic [15:0]     etype_q, op_q, ick_q, ipck_q, icmpck_q;
  logic [7:0]      proto_q, ity_q;
  logic [IpW-1:0]  tip_q;
  logic [SumW-1:0] sum_q, sum_d;
  logic            end_q, arp_rep_q, icmp_q;

  logic [7:0]      b;
  logic            pos_last, out_free, is_arp, is_icmp;
  logic [16:0]     icmp_sum;
  logic [PosW-1:0] raddr, moff, ioff;
  logic [7:0]      ram_rdata, hdr_byte;

  function automatic logic [15:0] fold16(input logic [SumW-1:0] s);
    logic [16:0] t;
    t = 17'(s[15:0]) + 17'(s[SumW-1:16]);
    return t[15:0] + 16'(t[16]);
  endfunction

  function automatic logic [7:0] mac_byte(input logic [MacW-1:0] m, input logic [2:0] sel);
    logic [7:0] r;
    case (sel)
      3'd0:    r = m[47:40];
      3'd1:    r = m[39:32];
      3'd2:    r = m[31:24];
      3'd3:    r = m[23:16];
      3'd4:    r = m[15:8];
      default: r = m[7:0];
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ip_byte(input logic [IpW-1:0] a, input logic [1:0] sel);
    logic [7:0] r;
    case (sel)
      2'd0:    r = a[31:24];
      2'd1:    r = a[23:16];
      2'd2:    r = a[15:8];
      default: r = a[7:0];
    endcase
    return r;
  endfunction

  assign b        = in_data_i.frame_byte;
  assign pos_last = (pos_q == PosLast);
  assign out_free = !out_valid_q || out_ready_i;
  assign is_arp   = (etype_q == EtherTypeArp);
  assign is_icmp  = !is_arp && (proto_q == IpProtoIcmp);
  assign icmp_sum = {1'b0, ~ick_q} + {1'b0, ~{ity_q, 8'h00}};

  always_comb begin
    sts_o.pos_last   = pos_last;
    sts_o.end_hdr    = end_q;
    sts_o.is_arp     = is_arp;
    sts_o.is_icmp    = is_icmp;
    sts_o.issue_done = (iss_q == PosHdrEnd);
    sts_o.pend       = pend_q;
    sts_o.out_free   = out_free;
  end

  always_comb begin
    sum_d = sum_q;
    if (pos_q == '0) begin
      sum_d = SumW'(ip_q[31:16]) + SumW'(ip_q[15:0]);
    end else if (pos_q inside {[14:23], [26:29]}) begin
      sum_d = sum_q + (pos_q[0] ? SumW'(b) : SumW'({b, 8'h00}));
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (cmd_i.capture) begin
      pos_d = (in_data_i.frame_end || pos_last) ? '0 : pos_q + PosW'(1);
    end
  end

  always_comb begin
    raddr = iss_q;
    if (iss_q < PosW'(6)) begin
      raddr = iss_q + PosW'(6);
    end else if (arp_rep_q && (iss_q >= PosW'(32))) begin
      raddr = iss_q - PosW'(10);
    end else if (icmp_q && (iss_q inside {[30:33]})) begin
      raddr = iss_q - PosW'(4);
    end
  end

  aier_ram #(
    .Width(8),
    .Depth(HdrLen)
  ) u_hdr_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.capture),
    .waddr_i(pos_q),
    .wdata_i(b),
    .re_i   (cmd_i.issue),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  assign moff = pidx_q - PosW'(arp_rep_q && (pidx_q >= PosW'(22)) ? 22 : 6);
  assign ioff = pidx_q - PosW'(arp_rep_q ? 28 : 26);

  always_comb begin
    hdr_byte = ram_rdata;
    if (pidx_q inside {[6:11]}) begin
      hdr_byte = mac_byte(mac_q, moff[2:0]);
    end else if (arp_rep_q) begin
      if (pidx_q == PosArpOp) begin
        hdr_byte = ArpOpReply[15:8];
      end else if (pidx_q == PosArpOp + PosW'(1)) begin
        hdr_byte = ArpOpReply[7:0];
      end else if (pidx_q inside {[22:27]}) begin
        hdr_byte = mac_byte(mac_q, moff[2:0]);
      end else if (pidx_q inside {[28:31]}) begin
        hdr_byte = ip_byte(ip_q, ioff[1:0]);
      end
    end else if (icmp_q) begin
      if (pidx_q == PosW'(24)) begin
        hdr_byte = ipck_q[15:8];
      end else if (pidx_q == PosW'(25)) begin
        hdr_byte = ipck_q[7:0];
      end else if (pidx_q inside {[26:29]}) begin
        hdr_byte = ip_byte(ip_q, ioff[1:0]);
      end else if (pidx_q == PosIcmpType) begin
        hdr_byte = IcmpEchoReply;
      end else if (pidx_q == PosIcmpCk) begin
        hdr_byte = icmpck_q[15:8];
      end else if (pidx_q == PosIcmpCk + PosW'(1)) begin
        hdr_byte = icmpck_q[7:0];
      end
    end
  end

  always_comb begin
    iss_d = iss_q;
    if (cmd_i.calc) begin
      iss_d = '0;
    end else if (cmd_i.issue) begin
      iss_d = iss_q + PosW'(1);
    end
    pend_d = pend_q;
    if (cmd_i.issue) begin
      pend_d = 1'b1;
    end else if (cmd_i.load_hdr) begin
      pend_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (cmd_i.load_hdr || cmd_i.load_pass) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_q       <= OurMacReset;
      ip_q        <= OurIpReset;
      pos_q       <= '0;
      iss_q       <= PosHdrEnd;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgOurMac: mac_q <= cfg_data_i;
          CfgOurIp:  ip_q  <= cfg_data_i[IpW-1:0];
          default:   mac_q <= mac_q;
        endcase
      end
      pos_q       <= pos_d;
      iss_q       <= iss_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      if (pos_q == PosEtype) etype_q[15:8] <= b;
      if (pos_q == PosEtype + PosW'(1)) etype_q[7:0] <= b;
      if (pos_q == PosArpOp) op_q[15:8] <= b;
      if (pos_q == PosArpOp + PosW'(1)) op_q[7:0] <= b;
      if (pos_q == PosIpProto) proto_q <= b;
      if (pos_q == PosIcmpType) ity_q <= b;
      if (pos_q == PosIcmpCk) ick_q[15:8] <= b;
      if (pos_q == PosIcmpCk + PosW'(1)) ick_q[7:0] <= b;
      if (pos_q >= PosArpTip) tip_q <= {tip_q[IpW-9:0], b};
      if (pos_last) end_q <= in_data_i.frame_end;
      sum_q <= sum_d;
    end
    if (cmd_i.calc) begin
      arp_rep_q <= is_arp && (op_q == ArpOpRequest) && (tip_q == ip_q);
      icmp_q    <= is_icmp;
      ipck_q    <= ~fold16(sum_q);
      icmpck_q  <= ~fold16(SumW'(icmp_sum));
    end
    if (cmd_i.issue) begin
      pidx_q <= iss_q;
    end
    if (cmd_i.load_hdr) begin
      out_q.reply_byte <= hdr_byte;
      out_q.reply_end  <= end_q && (pidx_q == PosLast);
      out_q.reply_kind <= icmp_q;
    end else if (cmd_i.load_pass) begin
      out_q.reply_byte <= b;
      out_q.reply_end  <= in_data_i.frame_end;
      out_q.reply_kind <= icmp_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hw/rtl/arp_icmp_echo_responder_unit.sv
// ----------------------------------------------------------------------------
// arp_icmp_echo_responder_unit
// Rewrites received ARP requests and ICMP frames into replies; the ICMP type is not checked.
// ----------------------------------------------------------------------------
//   Port group   Direction  Handshake               Contents
//   in_*         input      in_valid_i/in_ready_o   frame_byte, frame_end
//   out_*        output     out_valid_o/out_ready_i reply_byte, reply_end, reply_kind
//   cfg_*        input      cfg_we_i                our_mac (index 0), our_ip (index 1)
//
// Header bytes enter a 42-entry RAM at one per cycle; the input is then held in
// the checksum state for any header, and for a reply also while the header is released.
// Payload bytes pass at one per cycle while the output is not stalled.
// Reset is asynchronous and clears control, counters, station registers and
// the output valid; the RAM needs no clearing pass.
// An output stall holds the output and, in the release and payload, the input.
// ----------------------------------------------------------------------------
module arp_icmp_echo_responder_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  aier_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output aier_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [aier_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [aier_pkg::CfgDataW-1:0] cfg_data_i
);
  import aier_pkg::*;

  cmd_t cmd;
  sts_t sts;

  aier_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_end_i  (in_data_i.frame_end),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  aier_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

endmodule

// File: hw/rtl/aier_checker.sv
// ----------------------------------------------------------------------------
// aier_checker
// Port-level checks of the responder, bound to the top level.
// ----------------------------------------------------------------------------
`include "arp_icmp_echo_responder_unit_assert.svh"

module aier_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input aier_pkg::out_t out_data_o
);

  logic out_wait;
  logic out_mid;
  logic out_kind;

  assign out_wait = out_valid_o && !out_ready_i;
  assign out_mid  = out_valid_o && out_ready_i && !out_data_o.reply_end;
  assign out_kind = out_data_o.reply_kind;

  `AIER_ASSERT(a_hold, out_wait |=> out_valid_o && $stable(out_data_o), "Stalled output changed.")
  `AIER_ASSERT(a_kind, out_mid ##1 out_valid_o |-> $stable(out_kind), "Kind changed in a frame.")
  `AIER_ASSERT_ANY(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o, "Valid right after reset.")

endmodule

bind arp_icmp_echo_responder_unit aier_checker u_aier_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
